// File: src/dttd_pkg.sv
// shared types, constants and calendar tables for the date text to day count block
package dttd_pkg;

    localparam int TextBytes  = 8;
    localparam int CountWidth = 23;
    localparam int YearWidth  = 14;
    localparam int FieldWidth = 7;

    // days from year 0 to 1990-01-01 with a leap year every fourth year
    localparam int EpochYear = 1990;
    localparam int EpochDays = EpochYear * 365 + (EpochYear + 3) / 4;

    typedef logic signed [CountWidth-1:0] day_count_t;
    typedef logic [YearWidth-1:0]         year_t;
    typedef logic [FieldWidth-1:0]        field_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_DIGIT = 2'd1,
        STAT_BAD_DATE  = 2'd2
    } status_t;

    typedef struct packed {
        logic   bad_digit;
        year_t  year;
        field_t month;
        field_t day;
    } date_fields_t;

    // length of a month, index 0 is january
    function automatic logic [4:0] month_len(input logic [3:0] idx);
        logic [4:0] len;
        case (idx)
            4'd1:                      len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // days in the year before the first of a month, index 0 is january
    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] days;
        case (idx)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd59;
            4'd3:    days = 9'd90;
            4'd4:    days = 9'd120;
            4'd5:    days = 9'd151;
            4'd6:    days = 9'd181;
            4'd7:    days = 9'd212;
            4'd8:    days = 9'd243;
            4'd9:    days = 9'd273;
            4'd10:   days = 9'd304;
            4'd11:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

// File: src/dttd_parse.sv
// checks the eight ascii characters and forms binary year, month and day
module dttd_parse (
    input  logic [63:0]           date_text,
    output dttd_pkg::date_fields_t fields
);
    import dttd_pkg::*;

    logic [3:0] digit [TextBytes];
    logic [TextBytes-1:0] char_ok;

    always_comb begin
        for (int i = 0; i < TextBytes; i++) begin
            // first character sits in the top byte
            logic [7:0] ch;
            ch         = date_text[8*(TextBytes-1-i) +: 8];
            char_ok[i] = (ch[7:4] == 4'h3) && (ch[3:0] <= 4'd9);
            digit[i]   = ch[3:0];
        end
    end

    always_comb begin
        fields.bad_digit = ~&char_ok;
        fields.year  = YearWidth'(digit[0]) * YearWidth'(1000)
                     + YearWidth'(digit[1]) * YearWidth'(100)
                     + YearWidth'(digit[2]) * YearWidth'(10)
                     + YearWidth'(digit[3]);
        fields.month = FieldWidth'(digit[4]) * FieldWidth'(10) + FieldWidth'(digit[5]);
        fields.day   = FieldWidth'(digit[6]) * FieldWidth'(10) + FieldWidth'(digit[7]);
    end

endmodule

// File: src/dttd_count.sv
// validates month and day and forms the day count relative to the epoch
module dttd_count (
    input  dttd_pkg::date_fields_t fields,
    output dttd_pkg::day_count_t   day_count,
    output dttd_pkg::status_t      status
);
    import dttd_pkg::*;

    logic                  leap;
    logic                  month_ok;
    logic                  day_ok;
    logic [3:0]            midx;
    logic [CountWidth-1:0] year_days;
    logic [CountWidth-1:0] total;

    always_comb begin
        leap     = (fields.year[1:0] == 2'd0);
        month_ok = (fields.month >= FieldWidth'(1)) && (fields.month <= FieldWidth'(12));
        midx     = 4'(fields.month - FieldWidth'(1));
        day_ok   = (fields.day != '0) &&
                   ((fields.day <= FieldWidth'(month_len(midx))) ||
                    (leap && fields.month == FieldWidth'(2) && fields.day == FieldWidth'(29)));

        // days before the year: 365 per year plus one per leap year already passed
        year_days = CountWidth'(fields.year) * CountWidth'(365)
                  + CountWidth'((fields.year + YearWidth'(3)) >> 2);
        total     = year_days - CountWidth'(EpochDays)
                  + CountWidth'(days_before_month(midx))
                  + CountWidth'(leap && fields.month > FieldWidth'(2))
                  + CountWidth'(fields.day) - CountWidth'(1);

        if (fields.bad_digit) begin
            day_count = '1;
            status    = STAT_BAD_DIGIT;
        end else if (!month_ok || !day_ok) begin
            day_count = '0;
            status    = STAT_BAD_DATE;
        end else begin
            day_count = day_count_t'(total);
            status    = STAT_OK;
        end
    end

endmodule

// File: src/date_text_to_day_count.sv
// top level: converts an ascii YYYYMMDD date into a signed day count since 1990-01-01
//
// input channel s_*: one transaction carries eight ascii characters, first
// character in the top byte of s_tdata. result channel m_*: m_tdata holds the
// signed 23-bit day count, m_tuser the status (0 valid, 1 non-digit character,
// 2 month or day out of range).
// every input transaction gives exactly one result transaction, in order.
// an input date passes through an input register, then the digit check and
// closed-form day arithmetic feeding the result register. throughput is one
// date per cycle while the receiver does not stall; the two register stages each
// hold a transaction and a stage accepts whenever it is empty or is being
// emptied in the same cycle.
// when the receiver stalls, the result holds on m_* and the input register
// keeps one more date, after which s_tready drops.
// reset (aresetn low, synchronous) empties both stages; no result is pending.
module date_text_to_day_count (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] date_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [22:0] day_count, [23] zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import dttd_pkg::*;

    logic         in_valid_reg, in_valid_next;
    logic [63:0]  in_data_reg, in_data_next;
    logic         out_valid_reg, out_valid_next;
    day_count_t   out_count_reg, out_count_next;
    status_t      out_status_reg, out_status_next;

    date_fields_t fields;
    day_count_t   count;
    status_t      status;
    logic         out_ready;

    dttd_parse u_parse (
        .date_text (in_data_reg),
        .fields    (fields)
    );

    dttd_count u_count (
        .fields    (fields),
        .day_count (count),
        .status    (status)
    );

    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_comb begin
        in_valid_next   = in_valid_reg;
        in_data_next    = in_data_reg;
        out_valid_next  = out_valid_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        if (out_ready) begin
            out_valid_next  = in_valid_reg;
            out_count_next  = count;
            out_status_next = status;
        end
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_data_next  = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        in_data_reg    <= in_data_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg};
    assign m_tuser  = out_status_reg;

    // a bad character always reports a count of minus one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_BAD_DIGIT |-> m_tdata[22:0] == '1)
        else $error("bad digit result without count of -1");

    // an out-of-range date always reports a count of zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_BAD_DATE |-> m_tdata[22:0] == '0)
        else $error("invalid date result with nonzero count");

    // a held result must not be overwritten by the stage behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(out_count_reg) && $stable(out_status_reg))
        else $error("stalled result changed");

    // a transaction in the input stage moves forward once the result stage frees up
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && (!m_tvalid || m_tready) |=> m_tvalid)
        else $error("pending date not advanced to result stage");

    // reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

// File: dv/tb.sv
// testbench for date_text_to_day_count: ascii dates in, checked day counts and status out
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dttd_pkg::*;

    localparam logic [7:0] AsciiZero = 8'h30;
    localparam logic [7:0] AsciiNine = 8'h39;
    localparam int DaysPerYear = 365;
    localparam int EpochOffset = 1990 * DaysPerYear + (1990 + 3) / 4;
    localparam int MonthLen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int RandomDates = 1300;
    localparam int TailCycles = 10;

    typedef struct {
        logic [63:0] text;
        day_count_t  days;
        status_t     stat;
    } day_reading_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // [63:0] date_text
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [22:0] day_count, [23] zero
    logic [1:0]  m_tuser;        // [1:0] status

    logic [63:0]  pending_dates[$];
    day_reading_t awaited_counts[$];
    int           mismatches = 0;

    int send_gap = 0;
    int send_calm = 0;
    int recv_stall = 0;
    int recv_calm = 0;
    day_reading_t oldest;

    date_text_to_day_count dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic bit is_leap(input int year);
        return (year % 4) == 0;
    endfunction

    function automatic int days_in_month(input int year, input int month);
        return MonthLen[month-1] + ((is_leap(year) && month == 2) ? 1 : 0);
    endfunction

    // expected day count and status for one date text
    function automatic day_reading_t predict_day_count(input logic [63:0] text);
        day_reading_t res;
        int digits[8];
        int year;
        int month;
        int day;
        int total;
        logic [7:0] ch;
        res.text = text;
        for (int i = 0; i < 8; i++) begin
            ch = text[63-8*i -: 8];
            if (ch < AsciiZero || ch > AsciiNine) begin
                res.days = '1;
                res.stat = STAT_BAD_DIGIT;
                return res;
            end
            digits[i] = int'(ch - AsciiZero);
        end
        year = digits[0] * 1000 + digits[1] * 100 + digits[2] * 10 + digits[3];
        month = digits[4] * 10 + digits[5];
        day = digits[6] * 10 + digits[7];
        if (month < 1 || month > 12 || day < 1 || day > days_in_month(year, month)) begin
            res.days = '0;
            res.stat = STAT_BAD_DATE;
            return res;
        end
        total = year * DaysPerYear + (year + 3) / 4 - EpochOffset + day - 1;
        for (int m = 1; m < month; m++) begin
            total += days_in_month(year, m);
        end
        res.days = total[CountWidth-1:0];
        res.stat = STAT_OK;
        return res;
    endfunction

    function automatic logic [7:0] ascii_digit(input int value);
        return AsciiZero + 8'(value);
    endfunction

    // numbers up to 9999 / 99 / 99, written out as YYYYMMDD
    function automatic logic [63:0] date_text(input int year, input int month, input int day);
        return {ascii_digit(year / 1000), ascii_digit((year / 100) % 10),
                ascii_digit((year / 10) % 10), ascii_digit(year % 10),
                ascii_digit(month / 10), ascii_digit(month % 10),
                ascii_digit(day / 10), ascii_digit(day % 10)};
    endfunction

    function automatic logic [7:0] non_digit_byte();
        int r;
        r = $urandom_range(0, 245);
        return (r < 48) ? 8'(r) : 8'(r + 10);
    endfunction

    function automatic logic [63:0] random_valid_date();
        int year;
        int month;
        year = $urandom_range(0, 9999);
        month = $urandom_range(1, 12);
        return date_text(year, month, $urandom_range(1, days_in_month(year, month)));
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // input side: present queued dates, record a prediction per accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                awaited_counts.push_back(predict_day_count(s_tdata));
                if (send_calm > 0) begin
                    send_calm--;
                    send_gap = 0;
                end else if ($urandom_range(0, 49) == 0) begin
                    send_calm = $urandom_range(20, 80);
                    send_gap = 0;
                end else begin
                    send_gap = pick_gap();
                end
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_dates.size() > 0) begin
                s_tdata <= pending_dates.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side: random back-pressure and the field checks
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_counts.size() == 0) begin
                    report_mismatch($sformatf("unexpected result day_count %0d status %0d",
                                              $signed(m_tdata[22:0]), m_tuser));
                end else begin
                    oldest = awaited_counts.pop_front();
                    if (m_tdata[22:0] !== oldest.days)
                        report_mismatch($sformatf("date %h day_count %0d, expected %0d",
                                                  oldest.text, $signed(m_tdata[22:0]),
                                                  oldest.days));
                    if (m_tdata[23] !== 1'b0)
                        report_mismatch($sformatf("date %h pad bit of tdata set",
                                                  oldest.text));
                    if (m_tuser !== oldest.stat)
                        report_mismatch($sformatf("date %h status %0d, expected %s",
                                                  oldest.text, m_tuser, oldest.stat.name()));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (recv_calm > 0)
                    recv_calm--;
                else if ($urandom_range(0, 59) == 0)
                    recv_calm = $urandom_range(30, 120);
                else if ($urandom_range(0, 3) == 0)
                    recv_stall = pick_gap();
            end
        end
    end

    initial begin
        logic [63:0] text;
        int pick;
        int pos;

        // calendar corners, leap handling and every kind of bad input
        pending_dates.push_back(date_text(0, 1, 1));
        pending_dates.push_back(date_text(9999, 12, 31));
        pending_dates.push_back(date_text(1990, 1, 1));
        pending_dates.push_back(date_text(1989, 12, 31));
        pending_dates.push_back(date_text(1900, 2, 29));
        pending_dates.push_back(date_text(1999, 2, 29));
        pending_dates.push_back(date_text(0, 2, 29));
        pending_dates.push_back(date_text(2024, 3, 1));
        pending_dates.push_back(date_text(2023, 0, 15));
        pending_dates.push_back(date_text(2023, 13, 1));
        pending_dates.push_back(date_text(2023, 99, 99));
        pending_dates.push_back(date_text(2023, 4, 31));
        pending_dates.push_back(date_text(2023, 1, 0));
        pending_dates.push_back(date_text(2023, 12, 32));
        pending_dates.push_back(64'h0);
        pending_dates.push_back('1);
        for (int i = 0; i < 8; i++) begin
            text = date_text(2001, 6, 15);
            text[63-8*i -: 8] = (i % 2 == 0) ? AsciiZero - 8'd1 : AsciiNine + 8'd1;
            pending_dates.push_back(text);
        end

        for (int n = 0; n < RandomDates; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                text = random_valid_date();
            end else if (pick < 75) begin
                // month and day around the edges of their ranges
                if ($urandom_range(0, 3) == 0)
                    text = date_text($urandom_range(0, 9999), $urandom_range(0, 99),
                                     $urandom_range(0, 99));
                else
                    text = date_text($urandom_range(0, 9999), $urandom_range(0, 13),
                                     $urandom_range(0, 32));
            end else if (pick < 90) begin
                text = random_valid_date();
                pos = $urandom_range(0, 7);
                text[63-8*pos -: 8] = non_digit_byte();
            end else begin
                text = {$urandom, $urandom};
            end
            pending_dates.push_back(text);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_dates.size() > 0 || s_tvalid || awaited_counts.size() > 0)
            @(posedge aclk);
        repeat (TailCycles) @(posedge aclk);

        if (mismatches == 0)
            $display("PASS date_text_to_day_count");
        else
            $display("FAIL date_text_to_day_count");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("FAIL date_text_to_day_count");
        $finish;
    end

endmodule
